// ===== src/upvc_pkg.sv =====
// ---------------------------------------------------------------------------
// upvc_pkg
// Shared constants and types for the pixel-to-voxel compounding block.
// ---------------------------------------------------------------------------
`default_nettype none

package upvc_pkg;

    // Volume size in voxels along each axis.
    localparam int DIM_X = 128;
    localparam int DIM_Y = 128;
    localparam int DIM_Z = 128;
    localparam int NVOX  = DIM_X * DIM_Y * DIM_Z;

    // Fraction bits of the affine coefficients.
    localparam int COEF_FRAC_BITS = 16;

    localparam int ADDR_W = $clog2(NVOX);
    localparam int IX_W   = $clog2(DIM_X);
    localparam int IY_W   = $clog2(DIM_Y);
    localparam int IZ_W   = $clog2(DIM_Z);

    // Affine accumulator: two 32x11 products, a translation and the shifted origin.
    localparam int ACC_W = 46;
    localparam int IDX_W = ACC_W - COEF_FRAC_BITS;

    // Voxel word: occupied flag above the 8.8 intensity.
    localparam int VOX_W = 17;

    // Command codes.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_PIXEL = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z    = 3'd2;
    localparam logic [2:0] REG_HALF_WIDTH  = 3'd3;
    localparam logic [2:0] REG_MASK_SLOPE  = 3'd4;
    localparam logic [2:0] REG_MASK_RADIUS = 3'd5;

    localparam int NUM_COEFS = 12;

endpackage : upvc_pkg

`default_nettype wire

// ===== src/upvc_ram.sv =====
// ---------------------------------------------------------------------------
// upvc_ram
// Generic single-port RAM with a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module upvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule : upvc_ram

`default_nettype wire

// ===== src/ultrasound_pixel_to_voxel_compounding.sv =====
// ---------------------------------------------------------------------------
// ultrasound_pixel_to_voxel_compounding
// Nearest-neighbour compounding of ultrasound pixels into a voxel volume.
// ---------------------------------------------------------------------------
//
//  Channel   Signals                                   Transfer
//  --------  ----------------------------------------  -----------------------
//  command   start, cmd, coef_*, pixel_*, intensity,   start high, busy low
//            voxel_x/y/z
//  result    done, in_mask, in_volume, voxel_value,    done high, one cycle
//            occupied
//  config    psel, penable, pwrite, paddr, pwdata,     psel&penable&pwrite
//            prdata, pready
//
// A coefficient load or no-op is done at the accept edge; a voxel read reads
// the memory, then shows the result. A pixel takes the fan mask (products,
// then the check), each affine row in turn (a pair of 32x11 multiplies, then
// the sum), forming and reading the voxel address, the write-back and the result.
// The block works on one item at a time and holds busy high meanwhile.
// After reset the voxel memory is cleared one entry a cycle, all 2,097,152
// entries, with busy high; configuration writes are taken throughout.
// Results cannot be stalled: each is shown with done for a single cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ultrasound_pixel_to_voxel_compounding
    import upvc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // command channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         cmd,
    input  wire logic [3:0]         coef_index,
    input  wire logic signed [31:0] coef_value,
    input  wire logic [9:0]         pixel_col,
    input  wire logic [9:0]         pixel_row,
    input  wire logic [7:0]         intensity,
    input  wire logic [6:0]         voxel_x,
    input  wire logic [6:0]         voxel_y,
    input  wire logic [6:0]         voxel_z,
    // result channel
    output logic                    done,
    output logic                    in_mask,
    output logic                    in_volume,
    output logic [15:0]             voxel_value,
    output logic                    occupied,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_MPROD,
        S_MCHK,
        S_AMUL,
        S_ASUM,
        S_RD,
        S_WB
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic signed [12:0] origin_x_reg;
    logic signed [12:0] origin_y_reg;
    logic signed [12:0] origin_z_reg;
    logic [9:0]         half_width_reg;
    logic [15:0]        mask_slope_reg;
    logic [9:0]         mask_radius_reg;

    logic signed [31:0] coef_reg [NUM_COEFS];

    // Item being worked on.
    logic               is_pixel_reg;
    logic signed [10:0] x_reg;
    logic [9:0]         y_reg;
    logic [7:0]         int_reg;
    logic [1:0]         row_reg;
    logic [IX_W-1:0]    ix_reg;
    logic [IY_W-1:0]    iy_reg;
    logic [IZ_W-1:0]    iz_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  clr_reg;

    // Mask products.
    logic [20:0]        xx_reg;
    logic [19:0]        yy_reg;
    logic [19:0]        rr_reg;
    logic [25:0]        sx_reg;

    // Affine row products.
    logic signed [42:0] p0_reg;
    logic signed [42:0] p1_reg;
    logic signed [31:0] ct_reg;

    logic               done_reg;
    logic               in_mask_reg;
    logic               in_volume_reg;
    logic [15:0]        voxel_value_reg;
    logic               occupied_reg;

    // The configuration port never inserts wait states.
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        prdata = 32'd0;
        unique case (paddr[4:2])
            REG_ORIGIN_X:    prdata = {19'd0, origin_x_reg};
            REG_ORIGIN_Y:    prdata = {19'd0, origin_y_reg};
            REG_ORIGIN_Z:    prdata = {19'd0, origin_z_reg};
            REG_HALF_WIDTH:  prdata = {22'd0, half_width_reg};
            REG_MASK_SLOPE:  prdata = {16'd0, mask_slope_reg};
            REG_MASK_RADIUS: prdata = {22'd0, mask_radius_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // Column offset from the fan centre, taken at the accept edge.
    logic signed [10:0] x_next;
    assign x_next = $signed({1'b0, pixel_col}) - $signed({1'b0, half_width_reg});

    // The read-back index must fall inside the volume.
    logic rd_in_range;
    assign rd_in_range = (32'(voxel_x) < DIM_X) && (32'(voxel_y) < DIM_Y)
                      && (32'(voxel_z) < DIM_Z);

    logic [ADDR_W-1:0] rd_addr;
    assign rd_addr = ADDR_W'((32'(voxel_z) * DIM_Y + 32'(voxel_y)) * DIM_X
                             + 32'(voxel_x));

    // Fan mask: inside the radius, and either on the centre line with positive
    // depth or steep enough against the slope threshold.
    logic [9:0] ax;
    logic       mask_pass;
    assign ax = x_reg[10] ? 10'(-x_reg) : 10'(x_reg);
    assign mask_pass = ({1'b0, xx_reg} + {2'b0, yy_reg} <= {2'b0, rr_reg})
                    && ((x_reg == 11'sd0) ? (y_reg != 10'd0)
                                          : ({8'd0, y_reg, 8'd0} >= sx_reg));

    // Coefficient selection for the current affine row.
    logic signed [31:0] ca;
    logic signed [31:0] cb;
    logic signed [31:0] cc;
    logic signed [12:0] org;
    int                 dim;
    always_comb
    begin
        unique case (row_reg)
            2'd0:
            begin
                ca = coef_reg[0]; cb = coef_reg[1]; cc = coef_reg[9];
                org = origin_x_reg; dim = DIM_X;
            end
            2'd1:
            begin
                ca = coef_reg[3]; cb = coef_reg[4]; cc = coef_reg[10];
                org = origin_y_reg; dim = DIM_Y;
            end
            default:
            begin
                ca = coef_reg[6]; cb = coef_reg[7]; cc = coef_reg[11];
                org = origin_z_reg; dim = DIM_Z;
            end
        endcase
    end

    // Row sum, origin removal and round half up; the arithmetic shift floors.
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_sh;
    logic [IDX_W-1:0]        idx;
    logic                    idx_ok;
    assign acc = ACC_W'(p0_reg) + ACC_W'(p1_reg) + ACC_W'(ct_reg)
               - (ACC_W'(org) <<< COEF_FRAC_BITS) + HALF;
    assign acc_sh = acc >>> COEF_FRAC_BITS;
    assign idx = acc_sh[IDX_W-1:0];
    assign idx_ok = !idx[IDX_W-1] && (idx < IDX_W'(dim));

    logic [ADDR_W-1:0] px_addr;
    assign px_addr = ADDR_W'((32'(iz_reg) * DIM_Y + 32'(iy_reg)) * DIM_X
                             + 32'(ix_reg));

    // Voxel memory.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [VOX_W-1:0]  ram_wdata;
    logic [VOX_W-1:0]  ram_rdata;
    logic [16:0]       vsum;
    logic [15:0]       vnew;

    assign vsum = {1'b0, ram_rdata[15:0]} + {1'b0, int_reg, 8'd0};
    assign vnew = ram_rdata[16] ? vsum[16:1] : {int_reg, 8'd0};

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = addr_reg;
        ram_wdata = {1'b1, vnew};
        if (state_reg == S_CLR)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_WB)
        begin
            ram_we = is_pixel_reg;
        end
    end

    upvc_ram #(
        .WIDTH (VOX_W),
        .DEPTH (NVOX)
    ) u_vox_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLR;
            clr_reg         <= '0;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            origin_z_reg    <= '0;
            half_width_reg  <= 10'd324;
            mask_slope_reg  <= 16'd235;
            mask_radius_reg <= 10'd528;
            for (int i = 0; i < NUM_COEFS; i++)
            begin
                coef_reg[i] <= '0;
            end
            done_reg        <= 1'b0;
            in_mask_reg     <= 1'b0;
            in_volume_reg   <= 1'b0;
            voxel_value_reg <= '0;
            occupied_reg    <= 1'b0;
            row_reg         <= '0;
            is_pixel_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;

            if (cfg_wr)
            begin
                unique case (paddr[4:2])
                    REG_ORIGIN_X:    origin_x_reg    <= pwdata[12:0];
                    REG_ORIGIN_Y:    origin_y_reg    <= pwdata[12:0];
                    REG_ORIGIN_Z:    origin_z_reg    <= pwdata[12:0];
                    REG_HALF_WIDTH:  half_width_reg  <= pwdata[9:0];
                    REG_MASK_SLOPE:  mask_slope_reg  <= pwdata[15:0];
                    REG_MASK_RADIUS: mask_radius_reg <= pwdata[9:0];
                    default:         ;
                endcase
            end

            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ADDR_W'(NVOX - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        in_mask_reg     <= 1'b0;
                        in_volume_reg   <= 1'b0;
                        voxel_value_reg <= '0;
                        occupied_reg    <= 1'b0;
                        x_reg           <= x_next;
                        y_reg           <= pixel_row;
                        int_reg         <= intensity;
                        row_reg         <= '0;
                        is_pixel_reg    <= (cmd == CMD_PIXEL);
                        addr_reg        <= rd_addr;
                        unique case (cmd)
                            CMD_LOAD:
                            begin
                                if (coef_index < 4'(NUM_COEFS))
                                begin
                                    coef_reg[coef_index] <= coef_value;
                                end
                                done_reg <= 1'b1;
                            end
                            CMD_PIXEL:
                            begin
                                state_reg <= S_MPROD;
                            end
                            CMD_READ:
                            begin
                                if (rd_in_range)
                                begin
                                    state_reg <= S_RD;
                                end
                                else
                                begin
                                    done_reg <= 1'b1;
                                end
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_MPROD:
                begin
                    xx_reg    <= 21'(x_reg * x_reg);
                    yy_reg    <= y_reg * y_reg;
                    rr_reg    <= mask_radius_reg * mask_radius_reg;
                    sx_reg    <= mask_slope_reg * ax;
                    state_reg <= S_MCHK;
                end
                S_MCHK:
                begin
                    in_mask_reg <= mask_pass;
                    if (mask_pass)
                    begin
                        state_reg <= S_AMUL;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_AMUL:
                begin
                    p0_reg    <= ca * x_reg;
                    p1_reg    <= cb * $signed({1'b0, y_reg});
                    ct_reg    <= cc;
                    state_reg <= S_ASUM;
                end
                S_ASUM:
                begin
                    unique case (row_reg)
                        2'd0:    ix_reg <= IX_W'(idx);
                        2'd1:    iy_reg <= IY_W'(idx);
                        default: iz_reg <= IZ_W'(idx);
                    endcase
                    if (!idx_ok)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (row_reg == 2'd2)
                    begin
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        row_reg   <= row_reg + 1'b1;
                        state_reg <= S_AMUL;
                    end
                end
                S_RD:
                begin
                    // The pixel address is ready once all three indexes are in.
                    if (is_pixel_reg)
                    begin
                        addr_reg <= px_addr;
                    end
                    state_reg <= (is_pixel_reg && row_reg == 2'd2) ? S_RD : S_WB;
                    row_reg   <= '0;
                end
                S_WB:
                begin
                    if (is_pixel_reg)
                    begin
                        in_volume_reg <= 1'b1;
                    end
                    else
                    begin
                        voxel_value_reg <= ram_rdata[15:0];
                        occupied_reg    <= ram_rdata[16];
                    end
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign in_mask     = in_mask_reg;
    assign in_volume   = in_volume_reg;
    assign voxel_value = voxel_value_reg;
    assign occupied    = occupied_reg;

endmodule : ultrasound_pixel_to_voxel_compounding

`default_nettype wire
